// File: hdl/cbcd_pkg.sv
// ----------------------------------------------------------------------------
// cbcd_pkg: shared types and constants of the color blob centroid detector
// Field widths, register codes, reset values and the records passed between
// the front end, the pixel queue, the accumulator and the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cbcd_pkg;

  // largest frame the counters are allowed to cover
  localparam int MAX_WIDTH  = 640;
  localparam int MAX_HEIGHT = 480;

  // field widths
  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int CNT_W      = 19;
  localparam int SUM_W      = 28;
  localparam int FRAC_W     = 4;
  localparam int DVD_W      = SUM_W + FRAC_W;
  localparam int CCOL_W     = 14;
  localparam int CROW_W     = 13;
  localparam int SIZE_W     = 13;
  localparam int STEP_W     = $clog2(DVD_W);

  // ports
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 88;

  // pixel queue between front end and accumulator
  localparam int QUEUE_DEPTH = 4;

  // register reset values
  localparam logic [COL_W-1:0] FRAME_WIDTH_RST  = 10'd640;
  localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 9'd480;
  localparam logic [PIX_W-1:0] RED_MIN_RST      = 8'd150;
  localparam logic [PIX_W-1:0] GREEN_LOW_RST    = 8'd40;
  localparam logic [PIX_W-1:0] GREEN_HIGH_RST   = 8'd160;
  localparam logic [PIX_W-1:0] BLUE_MAX_RST     = 8'd90;
  localparam logic [PIX_W-1:0] RG_MARGIN_RST    = 8'd40;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_RED_MIN      = 3'd2,
    CFG_GREEN_LOW    = 3'd3,
    CFG_GREEN_HIGH   = 3'd4,
    CFG_BLUE_MAX     = 3'd5,
    CFG_RG_MARGIN    = 3'd6
  } cfg_index_t;

  // one classified pixel
  typedef struct packed {
    logic             hit;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             frame_end;
  } pix_t;

  // accumulator snapshot at a frame end
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] col_sum;
    logic [SUM_W-1:0] row_sum;
    logic [COL_W-1:0] min_col;
    logic [ROW_W-1:0] min_row;
    logic [COL_W-1:0] max_col;
    logic [ROW_W-1:0] max_row;
  } frame_t;

  // one frame result
  typedef struct packed {
    logic              found;
    logic [CNT_W-1:0]  match_count;
    logic [COL_W-1:0]  box_left;
    logic [ROW_W-1:0]  box_top;
    logic [COL_W-1:0]  box_right;
    logic [ROW_W-1:0]  box_bottom;
    logic [CCOL_W-1:0] centroid_col;
    logic [CROW_W-1:0] centroid_row;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/cbcd_front.sv
// ----------------------------------------------------------------------------
// cbcd_front: pixel intake and color classification
// Holds the configuration registers, tracks column and row, tests each pixel
// against the orange thresholds and pushes the tagged pixel into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cbcd_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [cbcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cbcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [cbcd_pkg::IN_TDATA_W-1:0]  in_tdata,   // red, green, blue
  input  wire logic                             q_full,
  output logic                                  push,
  output cbcd_pkg::pix_t                        push_entry
);

  localparam logic [cbcd_pkg::SIZE_W-1:0] MAXW = cbcd_pkg::SIZE_W'(cbcd_pkg::MAX_WIDTH);
  localparam logic [cbcd_pkg::SIZE_W-1:0] MAXH = cbcd_pkg::SIZE_W'(cbcd_pkg::MAX_HEIGHT);

  logic [cbcd_pkg::COL_W-1:0] frame_width_r;
  logic [cbcd_pkg::ROW_W-1:0] frame_height_r;
  logic [cbcd_pkg::PIX_W-1:0] red_min_r, green_low_r, green_high_r, blue_max_r, rg_margin_r;
  logic [cbcd_pkg::COL_W-1:0] col_r, col_nxt;
  logic [cbcd_pkg::ROW_W-1:0] row_r, row_nxt;

  logic [cbcd_pkg::PIX_W-1:0] red, green, blue;
  logic [cbcd_pkg::PIX_W:0]   green_plus_margin;
  logic [cbcd_pkg::COL_W-1:0] eff_width;
  logic [cbcd_pkg::ROW_W-1:0] eff_height;
  logic                       hit, row_end, frame_end;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= cbcd_pkg::FRAME_WIDTH_RST;
      frame_height_r <= cbcd_pkg::FRAME_HEIGHT_RST;
      red_min_r      <= cbcd_pkg::RED_MIN_RST;
      green_low_r    <= cbcd_pkg::GREEN_LOW_RST;
      green_high_r   <= cbcd_pkg::GREEN_HIGH_RST;
      blue_max_r     <= cbcd_pkg::BLUE_MAX_RST;
      rg_margin_r    <= cbcd_pkg::RG_MARGIN_RST;
    end else if (cfg_we) begin
      unique case (cbcd_pkg::cfg_index_t'(cfg_index))
        cbcd_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[cbcd_pkg::COL_W-1:0];
        cbcd_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[cbcd_pkg::ROW_W-1:0];
        cbcd_pkg::CFG_RED_MIN:      red_min_r      <= cfg_data[cbcd_pkg::PIX_W-1:0];
        cbcd_pkg::CFG_GREEN_LOW:    green_low_r    <= cfg_data[cbcd_pkg::PIX_W-1:0];
        cbcd_pkg::CFG_GREEN_HIGH:   green_high_r   <= cfg_data[cbcd_pkg::PIX_W-1:0];
        cbcd_pkg::CFG_BLUE_MAX:     blue_max_r     <= cfg_data[cbcd_pkg::PIX_W-1:0];
        cbcd_pkg::CFG_RG_MARGIN:    rg_margin_r    <= cfg_data[cbcd_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // color test
  always_comb begin
    red   = in_tdata[cbcd_pkg::PIX_W-1:0];
    green = in_tdata[2*cbcd_pkg::PIX_W-1:cbcd_pkg::PIX_W];
    blue  = in_tdata[3*cbcd_pkg::PIX_W-1:2*cbcd_pkg::PIX_W];
    green_plus_margin = {1'b0, green} + {1'b0, rg_margin_r};
    hit = (red > red_min_r) && (green > green_low_r) && (green < green_high_r) &&
          (blue < blue_max_r) && ({1'b0, red} > green_plus_margin) && (green > blue);
  end

  // effective frame size, clamped to 1..max
  always_comb begin
    if (frame_width_r == '0) begin
      eff_width = cbcd_pkg::COL_W'(1);
    end else if ({{(cbcd_pkg::SIZE_W-cbcd_pkg::COL_W){1'b0}}, frame_width_r} > MAXW) begin
      eff_width = MAXW[cbcd_pkg::COL_W-1:0];
    end else begin
      eff_width = frame_width_r;
    end
    if (frame_height_r == '0) begin
      eff_height = cbcd_pkg::ROW_W'(1);
    end else if ({{(cbcd_pkg::SIZE_W-cbcd_pkg::ROW_W){1'b0}}, frame_height_r} > MAXH) begin
      eff_height = MAXH[cbcd_pkg::ROW_W-1:0];
    end else begin
      eff_height = frame_height_r;
    end
  end

  // raster position and end of row / frame
  always_comb begin
    row_end   = ({1'b0, col_r} + (cbcd_pkg::COL_W+1)'(1)) >= {1'b0, eff_width};
    frame_end = row_end &&
                (({1'b0, row_r} + (cbcd_pkg::ROW_W+1)'(1)) >= {1'b0, eff_height});
    if (row_end) begin
      col_nxt = '0;
      row_nxt = frame_end ? '0 : row_r + cbcd_pkg::ROW_W'(1);
    end else begin
      col_nxt = col_r + cbcd_pkg::COL_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // queue side
  assign in_tready            = !q_full;
  assign push                 = in_tvalid && !q_full;
  assign push_entry.hit       = hit;
  assign push_entry.col       = col_r;
  assign push_entry.row       = row_r;
  assign push_entry.frame_end = frame_end;

endmodule
`default_nettype wire

// File: hdl/cbcd_queue.sv
// ----------------------------------------------------------------------------
// cbcd_queue: short pixel queue
// Decouples pixel intake from the accumulator so either side may stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cbcd_queue #(
  parameter int DEPTH = cbcd_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire cbcd_pkg::pix_t push_entry,
  input  wire logic           pop,
  output logic                q_valid,
  output logic                q_full,
  output cbcd_pkg::pix_t      q_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cbcd_pkg::pix_t     mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   fill_r;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + CNT_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - CNT_W'(1);
      end
    end
  end

  assign q_valid = (fill_r != '0);
  assign q_full  = (fill_r == CNT_W'(DEPTH));
  assign q_entry = mem_r[rd_ptr_r];

endmodule
`default_nettype wire

// File: hdl/cbcd_back.sv
// ----------------------------------------------------------------------------
// cbcd_back: blob accumulator
// Adds matching pixels to count, coordinate sums and bounding box; at a frame
// end hands the totals to the divider and clears for the next frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cbcd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire cbcd_pkg::pix_t q_entry,
  output logic                pop,
  input  wire logic           div_ready,
  output logic                div_start,
  output cbcd_pkg::frame_t    div_frame
);

  cbcd_pkg::frame_t acc_r, acc_nxt;

  // accumulator update for the pixel at the queue head
  always_comb begin
    acc_nxt = acc_r;
    if (q_entry.hit) begin
      acc_nxt.count   = acc_r.count + cbcd_pkg::CNT_W'(1);
      acc_nxt.col_sum = acc_r.col_sum +
                        {{(cbcd_pkg::SUM_W-cbcd_pkg::COL_W){1'b0}}, q_entry.col};
      acc_nxt.row_sum = acc_r.row_sum +
                        {{(cbcd_pkg::SUM_W-cbcd_pkg::ROW_W){1'b0}}, q_entry.row};
      if (q_entry.col < acc_r.min_col) acc_nxt.min_col = q_entry.col;
      if (q_entry.col > acc_r.max_col) acc_nxt.max_col = q_entry.col;
      if (q_entry.row < acc_r.min_row) acc_nxt.min_row = q_entry.row;
      if (q_entry.row > acc_r.max_row) acc_nxt.max_row = q_entry.row;
    end
  end

  // a frame end waits for the divider
  assign pop       = q_valid && (!q_entry.frame_end || div_ready);
  assign div_start = pop && q_entry.frame_end;
  assign div_frame = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || div_start) begin
      acc_r.count   <= '0;
      acc_r.col_sum <= '0;
      acc_r.row_sum <= '0;
      acc_r.min_col <= '1;
      acc_r.min_row <= '1;
      acc_r.max_col <= '0;
      acc_r.max_row <= '0;
    end else if (pop) begin
      acc_r <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/cbcd_div.sv
// ----------------------------------------------------------------------------
// cbcd_div: centroid divider and result register
// Two restoring dividers, one quotient bit per cycle, work out the column and
// row means with four fraction bits; the result register feeds the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cbcd_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire cbcd_pkg::frame_t frame,
  output logic                  ready,
  input  wire logic             out_tready,
  output logic                  out_valid,
  output cbcd_pkg::result_t     out_result
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  state_t                          state_r;
  logic [cbcd_pkg::STEP_W-1:0]     step_r;
  logic [cbcd_pkg::CNT_W-1:0]      dsr_r;
  logic [cbcd_pkg::CNT_W-1:0]      rem_c_r, rem_r_r;
  logic [cbcd_pkg::DVD_W-1:0]      dvd_c_r, dvd_r_r;
  logic                            found_r;
  logic [cbcd_pkg::COL_W-1:0]      left_r, right_r;
  logic [cbcd_pkg::ROW_W-1:0]      top_r, bottom_r;
  logic                            out_valid_r;
  cbcd_pkg::result_t               out_res_r;

  logic [cbcd_pkg::CNT_W:0]        sh_c, sh_r;
  logic [cbcd_pkg::CNT_W+1:0]      diff_c, diff_r;
  logic                            q_c, q_r;
  logic                            zero_frame;

  // one restoring step for each divider
  always_comb begin
    sh_c   = {rem_c_r, dvd_c_r[cbcd_pkg::DVD_W-1]};
    sh_r   = {rem_r_r, dvd_r_r[cbcd_pkg::DVD_W-1]};
    diff_c = {1'b0, sh_c} - {2'b00, dsr_r};
    diff_r = {1'b0, sh_r} - {2'b00, dsr_r};
    q_c    = !diff_c[cbcd_pkg::CNT_W+1];
    q_r    = !diff_r[cbcd_pkg::CNT_W+1];
  end

  assign zero_frame = (frame.count == '0);
  assign ready      = (state_r == ST_IDLE);

  // sequencer, dividers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result taken and nothing new loaded this cycle
      if (out_valid_r && out_tready && state_r != ST_HOLD) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            step_r   <= '0;
            dsr_r    <= frame.count;
            rem_c_r  <= '0;
            rem_r_r  <= '0;
            found_r  <= !zero_frame;
            if (zero_frame) begin
              dvd_c_r  <= '0;
              dvd_r_r  <= '0;
              left_r   <= '0;
              right_r  <= '0;
              top_r    <= '0;
              bottom_r <= '0;
              state_r  <= ST_HOLD;
            end else begin
              dvd_c_r  <= {frame.col_sum, {cbcd_pkg::FRAC_W{1'b0}}};
              dvd_r_r  <= {frame.row_sum, {cbcd_pkg::FRAC_W{1'b0}}};
              left_r   <= frame.min_col;
              right_r  <= frame.max_col;
              top_r    <= frame.min_row;
              bottom_r <= frame.max_row;
              state_r  <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          rem_c_r <= q_c ? diff_c[cbcd_pkg::CNT_W-1:0] : sh_c[cbcd_pkg::CNT_W-1:0];
          rem_r_r <= q_r ? diff_r[cbcd_pkg::CNT_W-1:0] : sh_r[cbcd_pkg::CNT_W-1:0];
          dvd_c_r <= {dvd_c_r[cbcd_pkg::DVD_W-2:0], q_c};
          dvd_r_r <= {dvd_r_r[cbcd_pkg::DVD_W-2:0], q_r};
          step_r  <= step_r + cbcd_pkg::STEP_W'(1);
          if (step_r == cbcd_pkg::STEP_W'(cbcd_pkg::DVD_W - 1)) begin
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          // load the result register once it is free
          if (!out_valid_r || out_tready) begin
            out_valid_r            <= 1'b1;
            out_res_r.found        <= found_r;
            out_res_r.match_count  <= found_r ? dsr_r : '0;
            out_res_r.box_left     <= left_r;
            out_res_r.box_top      <= top_r;
            out_res_r.box_right    <= right_r;
            out_res_r.box_bottom   <= bottom_r;
            out_res_r.centroid_col <= dvd_c_r[cbcd_pkg::CCOL_W-1:0];
            out_res_r.centroid_row <= dvd_r_r[cbcd_pkg::CROW_W-1:0];
            state_r                <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_res_r;

endmodule
`default_nettype wire

// File: hdl/color_blob_centroid_detector_top.sv
// ----------------------------------------------------------------------------
// color_blob_centroid_detector_top: orange blob count, box and centroid
// Classifies a raster RGB pixel stream and reports one result per frame.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready  tdata: red, green, blue
//  out_     master     out_tvalid/tready    tuser: found; tdata: count, box, centroid
//  cfg_     write      cfg_we               cfg_index, cfg_data
//
//  one pixel per cycle while no frame end is pending in the accumulator
//  a frame end with matches holds the centroid divider through load, 32 quotient
//  bits and result load, an empty frame through load and result load; a second frame end
//  meanwhile waits at the queue head, the 4-entry queue fills, in_tready drops
//  synchronous active-low reset clears counters, accumulators and registers;
//  out_tready low only holds the result register and, later, the divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module color_blob_centroid_detector_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [cbcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cbcd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  wire logic [cbcd_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // match_count [18:0], box_left [28:19], box_top [37:29], box_right [47:38],
  // box_bottom [56:48], centroid_col [70:57], centroid_row [83:71], zeros above
  output logic [cbcd_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // found [0]
  output logic                                   out_tuser
);

  localparam int PAYLOAD_W = $bits(cbcd_pkg::result_t) - 1;

  logic              q_full, q_valid, push, pop, div_ready, div_start;
  cbcd_pkg::pix_t    push_entry, q_entry;
  cbcd_pkg::frame_t  div_frame;
  cbcd_pkg::result_t result;

  cbcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  cbcd_queue #(
    .DEPTH (cbcd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_full     (q_full),
    .q_entry    (q_entry)
  );

  cbcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (pop),
    .div_ready (div_ready),
    .div_start (div_start),
    .div_frame (div_frame)
  );

  cbcd_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .frame      (div_frame),
    .ready      (div_ready),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_result (result)
  );

  // result packing, count in the lowest bits
  assign out_tuser = result.found;
  assign out_tdata = {{(cbcd_pkg::OUT_TDATA_W-PAYLOAD_W){1'b0}},
                      result.centroid_row, result.centroid_col,
                      result.box_bottom, result.box_right,
                      result.box_top, result.box_left, result.match_count};

  // checks
  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("empty frame result carries nonzero data");

  a_found_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> result.match_count != '0 &&
      result.box_left <= result.box_right && result.box_top <= result.box_bottom)
    else $error("found result with empty count or inverted box");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for color_blob_centroid_detector_top
// Streams raster RGB pixels through the detector under many frame sizes and
// threshold settings. A frame tracker predicts each end-of-frame report
// (found, count, bounding box, centroid) and checks every result transfer.
// Both sides idle and stall at random, the receiver holds off long enough to
// back up the pixel path, and the sender drains before every setting change.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  RANDOM_ITEMS   = 1100;
  localparam int  QUIET_ITEMS    = 200;
  localparam int  SETTLE_CYCLES  = 64;
  localparam int  DRAIN_LIMIT    = 5000;
  localparam int  HOLD_CYCLES    = 300;
  localparam int  TIMEOUT_NS     = 6_000_000;
  localparam logic [cbcd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

  // directed pixels, {red, green, blue}: two frames of 4x2, then two of 1x1
  localparam logic [23:0] PROBES [18] = '{
    24'hFF_9F_00, 24'h00_00_00, 24'hFF_FF_FF, 24'h96_64_32,
    24'h97_64_32, 24'hC8_A0_32, 24'hC8_28_1E, 24'hC8_64_5A,
    24'hBE_96_32, 24'hC8_50_50, 24'hC8_9F_59, 24'hC9_29_28,
    24'hBF_96_32, 24'hFF_FF_00, 24'h00_FF_FF, 24'hFF_00_FF,
    24'hFF_FE_00, 24'h01_01_00
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // raw cfg_data values, one per register
  typedef struct packed {
    logic [cbcd_pkg::CFG_DATA_W-1:0] width;
    logic [cbcd_pkg::CFG_DATA_W-1:0] height;
    logic [cbcd_pkg::CFG_DATA_W-1:0] red_min;
    logic [cbcd_pkg::CFG_DATA_W-1:0] green_low;
    logic [cbcd_pkg::CFG_DATA_W-1:0] green_high;
    logic [cbcd_pkg::CFG_DATA_W-1:0] blue_max;
    logic [cbcd_pkg::CFG_DATA_W-1:0] margin;
  } detector_setting_t;

  // frame tracker: mirrors counters, accumulators and registers of the block
  class frame_tracker;
    logic [cbcd_pkg::COL_W-1:0] width_reg;
    logic [cbcd_pkg::ROW_W-1:0] height_reg;
    logic [7:0]                 red_min, green_low, green_high, blue_max, margin;
    logic [cbcd_pkg::COL_W-1:0] col;
    logic [cbcd_pkg::ROW_W-1:0] row;
    logic [cbcd_pkg::CNT_W-1:0] hits;
    logic [cbcd_pkg::SUM_W-1:0] col_sum, row_sum;
    logic [cbcd_pkg::COL_W-1:0] min_col, max_col;
    logic [cbcd_pkg::ROW_W-1:0] min_row, max_row;
    cbcd_pkg::result_t          expected_frames[$];
    int unsigned                errors;

    function new();
      width_reg  = cbcd_pkg::FRAME_WIDTH_RST;
      height_reg = cbcd_pkg::FRAME_HEIGHT_RST;
      red_min    = cbcd_pkg::RED_MIN_RST;
      green_low  = cbcd_pkg::GREEN_LOW_RST;
      green_high = cbcd_pkg::GREEN_HIGH_RST;
      blue_max   = cbcd_pkg::BLUE_MAX_RST;
      margin     = cbcd_pkg::RG_MARGIN_RST;
      col        = '0;
      row        = '0;
      errors     = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      hits    = '0;
      col_sum = '0;
      row_sum = '0;
      min_col = '1;
      min_row = '1;
      max_col = '0;
      max_row = '0;
    endfunction

    // unknown indexes leave every register alone
    function void write_reg(logic [cbcd_pkg::CFG_IDX_W-1:0] idx,
                            logic [cbcd_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        cbcd_pkg::CFG_FRAME_WIDTH:  width_reg  = val[cbcd_pkg::COL_W-1:0];
        cbcd_pkg::CFG_FRAME_HEIGHT: height_reg = val[cbcd_pkg::ROW_W-1:0];
        cbcd_pkg::CFG_RED_MIN:      red_min    = val[7:0];
        cbcd_pkg::CFG_GREEN_LOW:    green_low  = val[7:0];
        cbcd_pkg::CFG_GREEN_HIGH:   green_high = val[7:0];
        cbcd_pkg::CFG_BLUE_MAX:     blue_max   = val[7:0];
        cbcd_pkg::CFG_RG_MARGIN:    margin     = val[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_frames.size();
    endfunction

    // one accepted pixel transfer
    function void note_pixel(pixel_t p);
      int unsigned       eff_w, eff_h, c, rw;
      bit                is_orange, row_end, frame_end;
      cbcd_pkg::result_t res;
      longint unsigned   n;
      eff_w = width_reg;
      if (eff_w < 1) eff_w = 1;
      if (eff_w > cbcd_pkg::MAX_WIDTH) eff_w = cbcd_pkg::MAX_WIDTH;
      eff_h = height_reg;
      if (eff_h < 1) eff_h = 1;
      if (eff_h > cbcd_pkg::MAX_HEIGHT) eff_h = cbcd_pkg::MAX_HEIGHT;
      c  = col;
      rw = row;

      // orange test
      is_orange = (p.red > red_min) && (p.green > green_low) && (p.green < green_high) &&
                  (p.blue < blue_max) && (p.green > p.blue) &&
                  (int'(p.red) > int'(p.green) + int'(margin));
      if (is_orange) begin
        hits    = hits + 1'b1;
        col_sum = col_sum + cbcd_pkg::SUM_W'(col);
        row_sum = row_sum + cbcd_pkg::SUM_W'(row);
        if (col < min_col) min_col = col;
        if (col > max_col) max_col = col;
        if (row < min_row) min_row = row;
        if (row > max_row) max_row = row;
      end

      // raster position, ends judged against the current size
      row_end   = (c + 1 >= eff_w);
      frame_end = row_end && (rw + 1 >= eff_h);
      if (row_end) begin
        col = '0;
        row = frame_end ? '0 : row + 1'b1;
      end else begin
        col = col + 1'b1;
      end

      // end-of-frame report, all zeros when nothing matched
      if (frame_end) begin
        res = '0;
        if (hits != 0) begin
          n                = hits;
          res.found        = 1'b1;
          res.match_count  = hits;
          res.box_left     = min_col;
          res.box_top      = min_row;
          res.box_right    = max_col;
          res.box_bottom   = max_row;
          res.centroid_col = cbcd_pkg::CCOL_W'((longint'(col_sum) << cbcd_pkg::FRAC_W) / n);
          res.centroid_row = cbcd_pkg::CROW_W'((longint'(row_sum) << cbcd_pkg::FRAC_W) / n);
        end
        expected_frames.push_back(res);
        clear_sums();
      end
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    // one result transfer against the oldest expected report
    function void check_result(logic found, logic [cbcd_pkg::OUT_TDATA_W-1:0] data);
      cbcd_pkg::result_t want;
      if (expected_frames.size() == 0) begin
        $error("result transfer with no frame report expected: found %0b, tdata %h",
               found, data);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      compare_field("found", 32'(want.found), 32'(found));
      compare_field("match_count", 32'(want.match_count), 32'(data[18:0]));
      compare_field("box_left", 32'(want.box_left), 32'(data[28:19]));
      compare_field("box_top", 32'(want.box_top), 32'(data[37:29]));
      compare_field("box_right", 32'(want.box_right), 32'(data[47:38]));
      compare_field("box_bottom", 32'(want.box_bottom), 32'(data[56:48]));
      compare_field("centroid_col", 32'(want.centroid_col), 32'(data[70:57]));
      compare_field("centroid_row", 32'(want.centroid_row), 32'(data[83:71]));
      compare_field("tdata padding", 32'd0, 32'(data[87:84]));
    endfunction

    function void flag_leftovers();
      foreach (expected_frames[i]) begin
        $error("frame report never arrived: found %0b, match_count %0d",
               expected_frames[i].found, expected_frames[i].match_count);
        errors++;
      end
    endfunction
  endclass

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             cfg_we     = 1'b0;
  logic [cbcd_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [cbcd_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [cbcd_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [cbcd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;

  frame_tracker      board = new();
  detector_setting_t cur;
  bit                quiet        = 1'b0;
  bit                hold_request = 1'b0;

  color_blob_centroid_detector_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("** color_blob_centroid_detector_top: FAILED **");
    $finish;
  end

  // receiver: checks result transfers, stalls in bursts, long hold on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready) board.check_result(out_tuser, out_tdata);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // one pixel transfer, with an optional idle burst ahead of it
  task automatic send_pixel(input pixel_t p);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.blue, p.green, p.red};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_pixel(p);
  endtask

  task automatic put_reg(input logic [cbcd_pkg::CFG_IDX_W-1:0] idx,
                         input logic [cbcd_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  // writes every register back to back, plus one write to an unused index
  task automatic apply_setting(input detector_setting_t s);
    cur = s;
    cfg_we <= 1'b1;
    put_reg(cbcd_pkg::CFG_FRAME_WIDTH, s.width);
    put_reg(cbcd_pkg::CFG_FRAME_HEIGHT, s.height);
    put_reg(cbcd_pkg::CFG_RED_MIN, s.red_min);
    put_reg(cbcd_pkg::CFG_GREEN_LOW, s.green_low);
    put_reg(cbcd_pkg::CFG_GREEN_HIGH, s.green_high);
    put_reg(cbcd_pkg::CFG_BLUE_MAX, s.blue_max);
    put_reg(cbcd_pkg::CFG_RG_MARGIN, s.margin);
    put_reg(CFG_UNUSED_INDEX, cbcd_pkg::CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // stop offering pixels, let every report arrive, then let the pipe settle
  task automatic pause_for_results();
    int spent;
    spent = 0;
    in_tvalid <= 1'b0;
    while (board.pending() != 0 && spent < DRAIN_LIMIT) begin
      @(posedge clk);
      spent++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // threshold near its nominal value most of the time, junk in the upper bits
  function automatic logic [cbcd_pkg::CFG_DATA_W-1:0] pick_level(logic [7:0] nominal);
    logic [7:0] v;
    int         t;
    case ($urandom_range(0, 19))
      0: v = 8'h00;
      1: v = 8'hFF;
      2, 3, 4, 5: v = 8'($urandom);
      default: begin
        t = int'(nominal) + int'($urandom_range(0, 40)) - 20;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        v = 8'(t);
      end
    endcase
    return {2'($urandom), v};
  endfunction

  // mostly tiny frames, now and then an edge size or one out of range
  function automatic detector_setting_t random_setting();
    detector_setting_t s;
    case ($urandom_range(0, 19))
      0: s.width = 10'd0;
      1: s.width = 10'd1023;
      2: s.width = 10'd640;
      3: s.width = 10'($urandom_range(9, 40));
      default: s.width = 10'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 19))
      0: s.height = 10'd0;
      1: s.height = 10'd480;
      2: s.height = 10'd511;
      default: s.height = 10'($urandom_range(1, 6));
    endcase
    s.height[9]  = 1'($urandom);
    s.red_min    = pick_level(cbcd_pkg::RED_MIN_RST);
    s.green_low  = pick_level(cbcd_pkg::GREEN_LOW_RST);
    s.green_high = pick_level(cbcd_pkg::GREEN_HIGH_RST);
    s.blue_max   = pick_level(cbcd_pkg::BLUE_MAX_RST);
    s.margin     = pick_level(cbcd_pkg::RG_MARGIN_RST);
    return s;
  endfunction

  // orange pixels for the current thresholds, near misses, and raw noise
  function automatic pixel_t make_pixel();
    pixel_t p;
    int     kind, g_lo, g_hi, b_top, r_lo;
    kind    = $urandom_range(0, 19);
    p.red   = 8'($urandom);
    p.green = 8'($urandom);
    p.blue  = 8'($urandom);
    if (kind >= 13) return p;
    g_lo = int'(cur.green_low[7:0]) + 1;
    g_hi = int'(cur.green_high[7:0]) - 1;
    if (g_lo > g_hi) return p;
    p.green = 8'($urandom_range(g_lo, g_hi));
    b_top = (cur.blue_max[7:0] < p.green) ? int'(cur.blue_max[7:0]) : int'(p.green);
    b_top = b_top - 1;
    if (b_top < 0) return p;
    p.blue = 8'($urandom_range(0, b_top));
    r_lo = int'(p.green) + int'(cur.margin[7:0]);
    if (r_lo < int'(cur.red_min[7:0])) r_lo = int'(cur.red_min[7:0]);
    r_lo = r_lo + 1;
    if (r_lo > 255) return p;
    p.red = 8'($urandom_range(r_lo, 255));
    // push one channel onto a threshold edge
    if (kind >= 9) begin
      case ($urandom_range(0, 5))
        0: p.red   = cur.red_min[7:0] + 8'($urandom_range(0, 1));
        1: p.green = cur.green_low[7:0] + 8'($urandom_range(0, 1));
        2: p.green = cur.green_high[7:0] - 8'($urandom_range(0, 1));
        3: p.blue  = cur.blue_max[7:0] - 8'($urandom_range(0, 1));
        4: p.red   = p.green + cur.margin[7:0] + 8'($urandom_range(0, 1));
        default: p.blue = p.green - 8'($urandom_range(0, 1));
      endcase
    end
    return p;
  endfunction

  task automatic send_random_pixels(input int count);
    repeat (count) send_pixel(make_pixel());
  endtask

  // stimulus
  initial begin
    detector_setting_t s;
    int                random_items;
    int                phase_no;
    int                count;
    random_items = 0;
    phase_no     = 0;

    // reset
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default thresholds on 4x2 frames, edges of every test
    s = '{width: 10'd4, height: 10'd2,
          red_min: cbcd_pkg::CFG_DATA_W'(cbcd_pkg::RED_MIN_RST),
          green_low: cbcd_pkg::CFG_DATA_W'(cbcd_pkg::GREEN_LOW_RST),
          green_high: cbcd_pkg::CFG_DATA_W'(cbcd_pkg::GREEN_HIGH_RST),
          blue_max: cbcd_pkg::CFG_DATA_W'(cbcd_pkg::BLUE_MAX_RST),
          margin: cbcd_pkg::CFG_DATA_W'(cbcd_pkg::RG_MARGIN_RST)};
    apply_setting(s);
    for (int i = 0; i < 16; i++) send_pixel(pixel_t'(PROBES[i]));

    // directed: zero size clamps to 1x1, all thresholds wide open
    pause_for_results();
    s = '{width: 10'd0, height: 10'd0, red_min: 10'd0, green_low: 10'd0,
          green_high: 10'd255, blue_max: 10'd255, margin: 10'd0};
    apply_setting(s);
    for (int i = 16; i < 18; i++) send_pixel(pixel_t'(PROBES[i]));

    // random phases; a phase may stop mid-frame, so sizes also change mid-frame
    while (random_items < RANDOM_ITEMS) begin
      quiet = (random_items >= RANDOM_ITEMS - QUIET_ITEMS);
      pause_for_results();
      case (phase_no)
        4: begin
          // widest row, height clamped up to one row
          s        = random_setting();
          s.width  = 10'd640;
          s.height = 10'd0;
          apply_setting(s);
          send_random_pixels(cbcd_pkg::MAX_WIDTH);
          random_items += cbcd_pkg::MAX_WIDTH;
        end
        6: begin
          // one pixel per frame while the receiver holds off
          s        = random_setting();
          s.width  = 10'd0;
          s.height = 10'd1;
          apply_setting(s);
          hold_request = 1'b1;
          send_random_pixels(40);
          random_items += 40;
        end
        9: begin
          // tallest frame, height clamped down, one column
          s        = random_setting();
          s.width  = 10'd1;
          s.height = 10'd511;
          apply_setting(s);
          send_random_pixels(cbcd_pkg::MAX_HEIGHT);
          random_items += cbcd_pkg::MAX_HEIGHT;
        end
        default: begin
          apply_setting(random_setting());
          count = $urandom_range(8, 60);
          send_random_pixels(count);
          random_items += count;
        end
      endcase
      phase_no++;
    end

    // drain and report
    pause_for_results();
    board.flag_leftovers();
    if (board.errors == 0) begin
      $display("** color_blob_centroid_detector_top: PASSED **");
    end else begin
      $display("** color_blob_centroid_detector_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/cbcd_pkg.sv
hdl/cbcd_front.sv
hdl/cbcd_queue.sv
hdl/cbcd_back.sv
hdl/cbcd_div.sv
hdl/color_blob_centroid_detector_top.sv
dv/testbench.sv
